>>> hdl/pcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants for the packed code predicate scan.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int CODE_W = 31;
  localparam int KW     = 5;
  localparam int PEND_W = 30;
  localparam int IN_W   = 64;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [KIND_W-1:0] PRED_EQ    = 2'd0;
  localparam logic [KIND_W-1:0] PRED_NE    = 2'd1;
  localparam logic [KIND_W-1:0] PRED_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] CFG_CODE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PRED_KIND  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_CMP_VALUE  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_UPPER      = 2'd3;

  localparam logic [KW-1:0] CODE_WIDTH_RST = 5'd8;

  typedef struct packed {
    logic [KW-1:0]     k;
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] cmp;
    logic [CODE_W-1:0] upper;
  } pcs_cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } pcs_qhead_t;

endpackage
`default_nettype wire

>>> hdl/pcs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_front
// Input side: accepts words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pcs_front #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [pcs_pkg::IN_W-1:0]  data_word,
  input  wire logic                      final_word,
  input  wire logic                      pop,
  output pcs_pkg::pcs_qhead_t            head,
  output logic [WORD_BITS-1:0]           head_word
);

  logic [WORD_BITS-1:0] mem_word [2];
  logic                 mem_last [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 do_pop;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_word[wr_ptr] <= data_word[WORD_BITS-1:0];
      mem_last[wr_ptr] <= final_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.last  = mem_last[rd_ptr];
  assign head_word  = mem_word[rd_ptr];

endmodule
`default_nettype wire

>>> hdl/pcs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcs_back
// Unpack side: pulls one code per cycle from the current word unless stalled,
// carries partial codes across words, registers each code and tests it.
// ----------------------------------------------------------------------------
module pcs_back #(
  parameter int WORD_BITS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pcs_pkg::pcs_cfg_t           cfg,
  input  wire pcs_pkg::pcs_qhead_t         head,
  input  wire logic [WORD_BITS-1:0]        head_word,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pcs_pkg::CODE_W-1:0]       code_seen,
  output logic                             hit,
  output logic                             end_of_word
);

  localparam int CW     = pcs_pkg::CODE_W;
  localparam int KW     = pcs_pkg::KW;
  localparam int PW     = pcs_pkg::PEND_W;
  localparam int LEFT_W = $clog2(WORD_BITS + 1);
  localparam int CMP_W  = (LEFT_W > KW) ? LEFT_W : KW;
  localparam int EXT_W  = WORD_BITS + CW;

  logic [PW-1:0]        acc;
  logic [KW-1:0]        cnt;
  logic [WORD_BITS-1:0] cur_word;
  logic [LEFT_W-1:0]    cur_left;
  logic                 cur_last;
  logic                 cur_valid;

  logic                 out_ok;
  logic [KW-1:0]        need;
  logic [CMP_W-1:0]     need_c;
  logic [CMP_W-1:0]     left_c;
  logic [CMP_W-1:0]     k_c;
  logic [CMP_W-1:0]     rem;
  logic                 full;
  logic                 word_done;
  logic [EXT_W-1:0]     ext_lo;
  logic [EXT_W-1:0]     ext_sh;
  logic [WORD_BITS-1:0] shifted;
  logic [CW-1:0]        lo;
  logic [CW-1:0]        mask;
  logic [CW-1:0]        code;
  logic [PW-1:0]        acc_part;

  assign out_ok  = !out_valid || !out_stall;
  assign pop     = !cur_valid && head.valid;

  assign need    = cfg.k - cnt;
  assign need_c  = CMP_W'(need);
  assign left_c  = CMP_W'(cur_left);
  assign k_c     = CMP_W'(cfg.k);
  assign full    = (left_c >= need_c);
  assign rem     = left_c - need_c;
  assign word_done = (rem < k_c);

  assign shifted = cur_word >> need;
  assign ext_lo  = {{CW{1'b0}}, cur_word};
  assign ext_sh  = {{CW{1'b0}}, shifted};
  assign lo      = ext_lo[CW-1:0];
  assign mask    = (CW'(1) << need) - CW'(1);
  assign code    = {1'b0, acc} | ((lo & mask) << cnt);
  assign acc_part = acc | (lo[PW-1:0] << cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        if (cnt >= cfg.k) begin
          acc <= '0;
          cnt <= '0;
        end
      end else if (cur_valid && out_ok) begin
        if (full) begin
          if (word_done) begin
            cur_valid <= 1'b0;
            if (cur_last) begin
              acc <= '0;
              cnt <= '0;
            end else begin
              acc <= ext_sh[PW-1:0];
              cnt <= rem[KW-1:0];
            end
          end else begin
            acc <= '0;
            cnt <= '0;
          end
        end else begin
          cur_valid <= 1'b0;
          if (cur_last) begin
            acc <= '0;
            cnt <= '0;
          end else begin
            acc <= acc_part;
            cnt <= cnt + KW'(cur_left);
          end
        end
      end
      if (out_ok) begin
        out_valid <= !pop && cur_valid && full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_word <= head_word;
      cur_left <= LEFT_W'(WORD_BITS);
      cur_last <= head.last;
    end else if (cur_valid && out_ok && full && !word_done) begin
      cur_word <= shifted;
      cur_left <= rem[LEFT_W-1:0];
    end
    if (!pop && cur_valid && out_ok && full) begin
      code_seen   <= code;
      end_of_word <= word_done;
    end
  end

  always_comb begin
    unique case (cfg.kind)
      pcs_pkg::PRED_EQ:    hit = (code_seen == cfg.cmp);
      pcs_pkg::PRED_NE:    hit = (code_seen != cfg.cmp);
      pcs_pkg::PRED_RANGE: hit = (code_seen >= cfg.cmp) && (code_seen < cfg.upper);
      default:             hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/packed_code_predicate_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// packed_code_predicate_scan
// Unpacks k-bit codes packed LSB first across a word stream and tests each
// against an equal, not-equal or range predicate, one result per code.
// ----------------------------------------------------------------------------
// Each word is first loaded into the unpack stage, which then extracts the
// codes that the word completes, one code per cycle while the output is not
// stalled; a word that completes no code only extends the partial code. The
// single code-extraction step of the unpack stage sets the rate. A two-entry
// queue in front takes new words while a word is unpacked; results leave via
// a registered output that may be stalled. The user must write configuration
// (code width, predicate, bounds) only while idle; it is not enforced.
module packed_code_predicate_scan #(
  parameter int WORD_BITS     = 64,
  parameter int MAX_CODE_BITS = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [pcs_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [pcs_pkg::CODE_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [pcs_pkg::IN_W-1:0]    data_word,
  input  wire logic                        final_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pcs_pkg::CODE_W-1:0]       code_seen,
  output logic                             hit,
  output logic                             end_of_word
);

  localparam int KW = pcs_pkg::KW;

  logic [KW-1:0]                 code_width;
  logic [pcs_pkg::KIND_W-1:0]    predicate_kind;
  logic [pcs_pkg::CODE_W-1:0]    compare_value;
  logic [pcs_pkg::CODE_W-1:0]    upper_bound;
  logic [KW-1:0]                 k_use;
  pcs_pkg::pcs_cfg_t             cfg;
  pcs_pkg::pcs_qhead_t           head;
  logic [WORD_BITS-1:0]          head_word;
  logic                          pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_width     <= pcs_pkg::CODE_WIDTH_RST;
      predicate_kind <= pcs_pkg::PRED_EQ;
      compare_value  <= '0;
      upper_bound    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcs_pkg::CFG_CODE_WIDTH: code_width     <= cfg_data[KW-1:0];
        pcs_pkg::CFG_PRED_KIND:  predicate_kind <= cfg_data[pcs_pkg::KIND_W-1:0];
        pcs_pkg::CFG_CMP_VALUE:  compare_value  <= cfg_data;
        pcs_pkg::CFG_UPPER:      upper_bound    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (code_width == '0) begin
      k_use = KW'(1);
    end else if (code_width > KW'(MAX_CODE_BITS)) begin
      k_use = KW'(MAX_CODE_BITS);
    end else begin
      k_use = code_width;
    end
  end

  assign cfg.k     = k_use;
  assign cfg.kind  = predicate_kind;
  assign cfg.cmp   = compare_value;
  assign cfg.upper = upper_bound;

  pcs_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_word  (data_word),
    .final_word (final_word),
    .pop        (pop),
    .head       (head),
    .head_word  (head_word)
  );

  pcs_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head        (head),
    .head_word   (head_word),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_seen   (code_seen),
    .hit         (hit),
    .end_of_word (end_of_word)
  );

endmodule
`default_nettype wire
